[design/lccp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lccp_pkg
// Types, constants and helpers shared by the coefficient compress/pack block.
// ----------------------------------------------------------------------------
package lccp_pkg;

  localparam int unsigned IN_W        = 13;
  localparam int unsigned OUT_W       = 12;
  localparam int unsigned SYM_W       = 12;
  localparam int unsigned BUF_W       = 19;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned BITS_W      = 4;
  localparam int unsigned NUM_W       = 24;
  localparam int unsigned RECIP_W     = 25;
  localparam int unsigned PROD_W      = NUM_W + RECIP_W;
  localparam int unsigned RECIP_SHIFT = 36;
  localparam int unsigned DEC_W       = 24;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 3;

  localparam logic [IN_W-1:0]    Q_MOD  = 13'd3329;
  localparam logic [10:0]        HALF_Q = 11'd1664;
  // ceil(2^36 / q): exact floor division by q for every numerator below 2^24.
  localparam logic [RECIP_W-1:0] RECIP  = 25'd20642679;

  localparam logic [BITS_W-1:0] RAW_BITS  = 4'd12;
  localparam logic [BITS_W-1:0] BYTE_BITS = 4'd8;

  // Width mode register codes.
  localparam logic [2:0] WM_BITS4  = 3'd0;
  localparam logic [2:0] WM_BITS5  = 3'd1;
  localparam logic [2:0] WM_BITS10 = 3'd2;
  localparam logic [2:0] WM_BITS11 = 3'd3;
  localparam logic [2:0] WM_BITS12 = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECTION  = 2'd0,
    CFG_WIDTH_MODE = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic              unpack;
    logic [BITS_W-1:0] bits;
  } lccp_cfg_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last;
  } lccp_sym_t;

  // Bits per coefficient; undefined modes behave as raw 12-bit mode.
  function automatic logic [BITS_W-1:0] coeff_bits(input logic [2:0] wmode);
    logic [BITS_W-1:0] b;
    unique case (wmode)
      WM_BITS4:  b = 4'd4;
      WM_BITS5:  b = 4'd5;
      WM_BITS10: b = 4'd10;
      WM_BITS11: b = 4'd11;
      default:   b = RAW_BITS;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

[design/lccp_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lccp_stream_if
// Valid/ready stream carrying one value and a last flag per transfer.
// ----------------------------------------------------------------------------
interface lccp_stream_if #(parameter int unsigned VALUE_W = 13) ();

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);

endinterface
`default_nettype wire

[design/lccp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lccp_front
// Accepts input items, reduces and compresses coefficients in two stages and
// writes one symbol per item into the queue; unpacking passes the low byte.
// ----------------------------------------------------------------------------
module lccp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  lccp_pkg::lccp_cfg_t cfg,
  lccp_stream_if.sink         in_ch,
  output logic                q_wr,
  output lccp_pkg::lccp_sym_t q_wdata,
  input  logic                q_full
);
  import lccp_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  logic [IN_W-1:0]   s1_x_r, s1_x_nxt;
  logic              s1_last_r;
  logic              s2_valid_r, s2_valid_nxt;
  lccp_sym_t         s2_r, s2_nxt;

  logic              s1_free, s2_free, in_fire;
  logic [NUM_W-1:0]  num;
  logic [PROD_W-1:0] prod;
  logic [SYM_W-1:0]  quot, mask;

  assign s2_free     = !s2_valid_r || !q_full;
  assign s1_free     = !s1_valid_r || s2_free;
  assign in_ch.ready = s1_free;
  assign in_fire     = in_ch.valid && s1_free;

  assign q_wr    = s2_valid_r && !q_full;
  assign q_wdata = s2_r;

  // Stage 1: conditional subtraction of q when packing.
  always_comb begin
    if (!cfg.unpack && (in_ch.value >= Q_MOD)) begin
      s1_x_nxt = in_ch.value - Q_MOD;
    end else begin
      s1_x_nxt = in_ch.value;
    end
    s1_valid_nxt = s1_free ? in_fire : s1_valid_r;
  end

  // Stage 2, packing with d < 12: round(x*2^d/q) mod 2^d by reciprocal multiply.
  always_comb begin
    num  = (NUM_W'(s1_x_r) << cfg.bits) + NUM_W'(HALF_Q);
    prod = PROD_W'(num) * PROD_W'(RECIP);
    quot = prod[RECIP_SHIFT +: SYM_W];
    mask = (SYM_W'(1) << cfg.bits) - SYM_W'(1);
    if (cfg.unpack) begin
      s2_nxt.sym = {{(SYM_W-8){1'b0}}, s1_x_r[7:0]};
    end else if (cfg.bits == RAW_BITS) begin
      s2_nxt.sym = s1_x_r[SYM_W-1:0];
    end else begin
      s2_nxt.sym = quot & mask;
    end
    s2_nxt.last  = s1_last_r;
    s2_valid_nxt = s2_free ? s1_valid_r : s2_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_x_r    <= s1_x_nxt;
      s1_last_r <= in_ch.last;
    end
    if (s2_free) begin
      s2_r <= s2_nxt;
    end
  end

endmodule
`default_nettype wire

[design/lccp_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lccp_fifo
// Short symbol queue between the front and back parts.
// ----------------------------------------------------------------------------
module lccp_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  lccp_pkg::lccp_sym_t wr_data,
  output logic                full,
  input  logic                rd_en,
  output lccp_pkg::lccp_sym_t rd_data,
  output logic                empty
);
  import lccp_pkg::*;

  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  lccp_sym_t          mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;

  assign full    = (fill_r == FILL_W'(DEPTH));
  assign empty   = (fill_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      fill_nxt = fill_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

[design/lccp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lccp_back
// Bit buffer that merges queued symbols and emits one byte or one restored
// coefficient per cycle through the output register while out_ch is ready.
// ----------------------------------------------------------------------------
module lccp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  lccp_pkg::lccp_cfg_t cfg,
  input  logic                cfg_clear,
  input  logic                head_valid,
  input  lccp_pkg::lccp_sym_t head,
  output logic                head_pop,
  lccp_stream_if.source       out_ch
);
  import lccp_pkg::*;

  logic [BUF_W-1:0]  buf_r, buf_nxt, buf_p, base_buf;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_p, base_cnt, rem, unit5;
  logic              last_r, last_nxt, last_p;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_value_r, out_value_nxt;
  logic              out_last_r, out_last_nxt;

  logic [BITS_W-1:0] unit, in_w;
  logic              have_full, flush_part, want_emit, out_free, emit, emit_last;
  logic              done_p, take;
  logic [SYM_W-1:0]  grp_mask, grp, dec_val, emit_val;
  logic [DEC_W-1:0]  dec_prod, dec_sum;

  assign out_ch.valid = out_valid_r;
  assign out_ch.value = out_value_r;
  assign out_ch.last  = out_last_r;
  assign head_pop     = take;

  always_comb begin
    unit  = cfg.unpack ? cfg.bits : BYTE_BITS;
    in_w  = cfg.unpack ? BYTE_BITS : cfg.bits;
    unit5 = CNT_W'(unit);
    rem   = cnt_r - unit5;

    have_full  = (cnt_r >= unit5);
    // When packing, a leftover partial byte goes out zero-padded after the last item.
    flush_part = last_r && !cfg.unpack && (cnt_r != '0);
    want_emit  = have_full || flush_part;
    out_free   = !out_valid_r || out_ch.ready;
    emit       = want_emit && out_free;

    if (cfg.unpack) begin
      emit_last = last_r && (rem < unit5);
    end else begin
      emit_last = last_r && (cnt_r <= CNT_W'(BYTE_BITS));
    end

    grp_mask = (SYM_W'(1) << cfg.bits) - SYM_W'(1);
    grp      = buf_r[SYM_W-1:0] & grp_mask;
    dec_prod = DEC_W'(grp) * DEC_W'(Q_MOD);
    dec_sum  = dec_prod + (DEC_W'(1) << (cfg.bits - 4'd1));
    if (cfg.bits == RAW_BITS) begin
      dec_val = grp;
    end else begin
      dec_val = SYM_W'(dec_sum >> cfg.bits);
    end
    emit_val = cfg.unpack ? dec_val : {{(OUT_W-8){1'b0}}, buf_r[7:0]};

    // Buffer state as it stands after this cycle's emission.
    if (emit && emit_last) begin
      buf_p  = '0;
      cnt_p  = '0;
      last_p = 1'b0;
    end else if (emit) begin
      buf_p  = buf_r >> unit;
      cnt_p  = rem;
      last_p = last_r;
    end else begin
      buf_p  = buf_r;
      cnt_p  = cnt_r;
      last_p = last_r;
    end

    done_p = (cnt_p < unit5) && !(last_p && !cfg.unpack && (cnt_p != '0));
    take   = done_p && head_valid;

    // Bits left over after a last item that never formed a coefficient are dropped.
    base_buf = last_p ? '0 : buf_p;
    base_cnt = last_p ? '0 : cnt_p;

    if (take) begin
      buf_nxt  = base_buf | (BUF_W'(head.sym) << base_cnt);
      cnt_nxt  = base_cnt + CNT_W'(in_w);
      last_nxt = head.last;
    end else begin
      buf_nxt  = buf_p;
      cnt_nxt  = cnt_p;
      last_nxt = last_p;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = emit_val;
      out_last_nxt  = emit_last;
    end else begin
      out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
      out_value_nxt = out_value_r;
      out_last_nxt  = out_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r       <= '0;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (cfg_clear) begin
      buf_r       <= '0;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= out_valid_nxt;
    end else begin
      buf_r       <= buf_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule
`default_nettype wire

[design/lattice_coeff_compress_pack.sv]
`timescale 1ns / 1ps
`default_nettype none
// An input passes front stages 1 and 2, the queue, the bit buffer and the output register.
// Throughput: one input per cycle unless stalled; the output register gives one result per
// cycle while out_ch is ready; an item with two or three results holds up the back part.
// Reset (synchronous, rst_n low) empties the pipeline, queue and bit buffer and selects
// pack mode with raw 12-bit coefficients.
// ----------------------------------------------------------------------------
// lattice_coeff_compress_pack
// Streaming compress-and-pack / unpack-and-decompress engine for q = 3329.
// ----------------------------------------------------------------------------
module lattice_coeff_compress_pack #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  lccp_stream_if.sink                        in_ch,
  lccp_stream_if.source                      out_ch,
  input  logic                               cfg_we,
  input  logic [lccp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lccp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import lccp_pkg::*;

  logic      dir_r, dir_nxt;
  logic [2:0] wmode_r, wmode_nxt;
  logic      cfg_clear;
  lccp_cfg_t cfg;

  logic      q_wr, q_full, q_empty, q_rd;
  lccp_sym_t q_wdata, q_rdata;

  always_comb begin
    dir_nxt   = dir_r;
    wmode_nxt = wmode_r;
    cfg_clear = 1'b0;
    if (cfg_we && (cfg_index == CFG_DIRECTION)) begin
      dir_nxt   = cfg_wdata[0];
      cfg_clear = 1'b1;
    end else if (cfg_we && (cfg_index == CFG_WIDTH_MODE)) begin
      wmode_nxt = cfg_wdata[2:0];
      cfg_clear = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r   <= 1'b0;
      wmode_r <= WM_BITS12;
    end else begin
      dir_r   <= dir_nxt;
      wmode_r <= wmode_nxt;
    end
  end

  assign cfg.unpack = dir_r;
  assign cfg.bits   = coeff_bits(wmode_r);

  lccp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_ch   (in_ch),
    .q_wr    (q_wr),
    .q_wdata (q_wdata),
    .q_full  (q_full)
  );

  lccp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  lccp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cfg_clear  (cfg_clear),
    .head_valid (!q_empty),
    .head       (q_rdata),
    .head_pop   (q_rd),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire
